### hw/rtl/efc_pkg.sv
package efc_pkg;

  localparam int CordicSteps   = 16;
  localparam int AngleFracBits = 16;

  localparam int GainW  = 16;
  localparam int SpeedW = 24;
  localparam int KeyW   = 6;
  localparam int MouseW = 16;
  localparam int PosW   = 32;
  localparam int VecW   = 16;
  localparam int CfgAddrW = 1;
  localparam int CfgDataW = 24;

  localparam logic [CfgAddrW-1:0] RegMouseGain = 1'd0;
  localparam logic [CfgAddrW-1:0] RegMoveSpeed = 1'd1;

  localparam logic [GainW-1:0]  GainReset  = 16'd6554;
  localparam logic [SpeedW-1:0] SpeedReset = 24'd3277;

  // CORDIC angles are degrees in Q.24, x/y in signed Q3.30
  localparam int ZW = 36;
  localparam int XW = 34;
  localparam logic signed [XW-1:0] CordicK = 34'sd652032875;

  function automatic logic signed [ZW-1:0] atan_deg(input logic [4:0] i);
    case (i)
      5'd0:  atan_deg = 36'sd754974720;
      5'd1:  atan_deg = 36'sd445687602;
      5'd2:  atan_deg = 36'sd235489088;
      5'd3:  atan_deg = 36'sd119537938;
      5'd4:  atan_deg = 36'sd60000934;
      5'd5:  atan_deg = 36'sd30029717;
      5'd6:  atan_deg = 36'sd15018523;
      5'd7:  atan_deg = 36'sd7509720;
      5'd8:  atan_deg = 36'sd3754917;
      5'd9:  atan_deg = 36'sd1877466;
      5'd10: atan_deg = 36'sd938734;
      5'd11: atan_deg = 36'sd469367;
      5'd12: atan_deg = 36'sd234684;
      5'd13: atan_deg = 36'sd117342;
      5'd14: atan_deg = 36'sd58671;
      5'd15: atan_deg = 36'sd29335;
      5'd16: atan_deg = 36'sd14668;
      5'd17: atan_deg = 36'sd7334;
      5'd18: atan_deg = 36'sd3667;
      5'd19: atan_deg = 36'sd1833;
      5'd20: atan_deg = 36'sd917;
      5'd21: atan_deg = 36'sd458;
      5'd22: atan_deg = 36'sd229;
      5'd23: atan_deg = 36'sd115;
      default: atan_deg = '0;
    endcase
  endfunction

  typedef struct packed {
    logic [KeyW-1:0]          key_mask;
    logic signed [MouseW-1:0] mouse_dx;
    logic signed [MouseW-1:0] mouse_dy;
  } in_item_t;

  typedef struct packed {
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [PosW-1:0] pos_z;
    logic signed [VecW-1:0] dir_x;
    logic signed [VecW-1:0] dir_y;
    logic signed [VecW-1:0] dir_z;
    logic signed [VecW-1:0] up_x;
    logic signed [VecW-1:0] up_y;
    logic signed [VecW-1:0] up_z;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic signed [ZW-1:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic done;
    logic signed [XW-1:0] cos_v;
    logic signed [XW-1:0] sin_v;
  } cordic_rsp_t;

endpackage

### hw/rtl/efc_stream_if.sv
interface efc_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/efc_cordic.sv
module efc_cordic #(
  parameter int CORDIC_STEPS = efc_pkg::CordicSteps
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  efc_pkg::cordic_req_t req_i,
  output efc_pkg::cordic_rsp_t rsp_o
);
  import efc_pkg::*;

  localparam int Steps = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam logic signed [ZW-1:0] Ninety = 36'sd1509949440;
  localparam logic signed [ZW-1:0] Half   = 36'sd3019898880;
  localparam logic signed [XW-1:0] One30  = 34'sd1073741824;

  logic signed [XW-1:0] x_q, y_q;
  logic signed [ZW-1:0] z_q;
  logic [4:0] i_q;
  logic busy_q, neg_q, done_q;
  logic signed [XW-1:0] xn, yn;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        i_q <= i_q + 5'd1;
        if (i_q == 5'(Steps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q <= CordicK;
      y_q <= '0;
      if (req_i.angle > Ninety) begin
        z_q <= req_i.angle - Half; neg_q <= 1'b1;
      end else if (req_i.angle < -Ninety) begin
        z_q <= req_i.angle + Half; neg_q <= 1'b1;
      end else begin
        z_q <= req_i.angle; neg_q <= 1'b0;
      end
    end else if (busy_q) begin
      if (!z_q[ZW-1]) begin
        x_q <= x_q - (y_q >>> i_q);
        y_q <= y_q + (x_q >>> i_q);
        z_q <= z_q - atan_deg(i_q);
      end else begin
        x_q <= x_q + (y_q >>> i_q);
        y_q <= y_q - (x_q >>> i_q);
        z_q <= z_q + atan_deg(i_q);
      end
    end
  end

  always_comb begin
    xn = neg_q ? -x_q : x_q;
    yn = neg_q ? -y_q : y_q;
    rsp_o.done  = done_q;
    rsp_o.cos_v = (xn > One30) ? One30 : ((xn < -One30) ? -One30 : xn);
    rsp_o.sin_v = (yn > One30) ? One30 : ((yn < -One30) ? -One30 : yn);
  end
endmodule

### hw/rtl/euler_fly_camera_update_core.sv
// Euler-angle fly camera update, one frame per request.
// Input channel in_if carries key_mask, mouse_dx and mouse_dy; output
// channel out_if carries position, view direction and up vector.
// Configuration: cfg_we_i writes register cfg_idx_i (0 mouse_gain,
// 1 move_speed) with cfg_wdata_i; write only while idle.
// Per request, one CORDIC unit runs yaw then pitch one rotation per cycle,
// and one shared 34x34 multiplier forms the products and key moves in
// turn.
// in_if.ready is high only when the block is idle and the output register
// is empty, so one request is in flight at a time.
// The result sits in the output register until taken; a stalled receiver
// holds the block off from taking a new request.
// Reset: position zero, yaw -90 degrees, pitch zero, registers at defaults.
module euler_fly_camera_update_core #(
  parameter int CORDIC_STEPS    = efc_pkg::CordicSteps,
  parameter int ANGLE_FRAC_BITS = efc_pkg::AngleFracBits
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [efc_pkg::CfgAddrW-1:0] cfg_idx_i,
  input  logic [efc_pkg::CfgDataW-1:0] cfg_wdata_i,
  efc_stream_if.sink   in_if,
  efc_stream_if.source out_if
);
  import efc_pkg::*;

  localparam int AF  = ANGLE_FRAC_BITS;
  localparam int AW  = AF + 10;
  localparam int DW  = 48;
  localparam logic signed [AW-1:0] Full  = AW'(360) <<< AF;
  localparam logic signed [AW-1:0] HalfA = AW'(180) <<< AF;
  localparam logic signed [AW-1:0] PLim  = AW'(89) <<< AF;
  localparam logic signed [AW-1:0] YawReset = -(AW'(90) <<< AF);

  localparam logic [4:0] S_IDLE = 5'd0, S_MULX = 5'd1, S_MULY = 5'd2,
    S_WRAP = 5'd3, S_YAW = 5'd4, S_YAWW = 5'd5, S_PIT = 5'd6,
    S_PITW = 5'd7, S_M0 = 5'd8, S_M1 = 5'd9, S_M2 = 5'd10, S_M3 = 5'd11,
    S_K0 = 5'd12, S_K1 = 5'd13, S_K2 = 5'd14, S_K3 = 5'd15, S_K4 = 5'd16,
    S_POS = 5'd17, S_OUT = 5'd18, S_REM = 5'd19;

  logic [GainW-1:0]  gain_q;
  logic [SpeedW-1:0] speed_q;
  logic signed [PosW-1:0] pos_q [3];
  logic signed [AW-1:0] yaw_q, pitch_q;
  logic [4:0] st_q;
  in_item_t it_q;
  logic signed [DW-1:0] ddx_q, ddy_q;
  logic signed [XW-1:0] cy_q, sy_q, cp_q, sp_q;
  logic signed [VecW-1:0] d_q [3], u_q [3], rt0_q, rt2_q;
  logic signed [DW-1:0] fwd_q [3], side_q [3];
  logic signed [DW-1:0] qest_q;
  logic out_v_q;
  out_item_t out_q;

  // shared multiplier
  logic signed [XW-1:0] ma, mb;
  logic signed [2*XW-1:0] mp;
  assign mp = ma * mb;

  cordic_req_t creq;
  cordic_rsp_t crsp;
  efc_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(creq), .rsp_o(crsp));

  function automatic logic signed [ZW-1:0] to_q24(input logic signed [AW-1:0] a);
    logic signed [ZW+24:0] w;
    w = (ZW+25)'(a);
    if (AF <= 24) to_q24 = ZW'(w <<< (24 - AF));
    else to_q24 = ZW'(w >>> (AF - 24));
  endfunction

  function automatic logic signed [VecW-1:0] to14(input logic signed [2*XW-1:0] v);
    logic signed [2*XW-1:0] r;
    r = (v + 68'sd32768) >>> 16;
    if (r > 68'sd16384) to14 = 16'sd16384;
    else if (r < -68'sd16384) to14 = -16'sd16384;
    else to14 = VecW'(r);
  endfunction

  function automatic logic signed [2*XW-1:0] r30(input logic signed [2*XW-1:0] v);
    r30 = (v + (68'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic logic signed [DW-1:0] r14(input logic signed [2*XW-1:0] v);
    r14 = DW'((v + 68'sd8192) >>> 14);
  endfunction

  function automatic logic signed [DW-1:0] rescale_m(input logic signed [2*XW-1:0] p);
    logic signed [2*XW+20:0] w;
    w = (2*XW+21)'(p);
    if (AF >= 16) rescale_m = DW'(w <<< (AF - 16));
    else rescale_m = DW'(w >>> (16 - AF));
  endfunction

  logic [1:0] k;
  always_comb begin
    k = 2'd0;
    case (st_q)
      S_K1: k = 2'd1;
      S_K2: k = 2'd2;
      default: k = 2'd0;
    endcase
    ma = '0; mb = '0;
    case (st_q)
      S_MULX: begin ma = XW'(it_q.mouse_dx); mb = XW'({1'b0, gain_q}); end
      S_MULY: begin ma = XW'(it_q.mouse_dy); mb = XW'({1'b0, gain_q}); end
      S_M0: begin ma = cy_q; mb = cp_q; end
      S_M1: begin ma = sy_q; mb = cp_q; end
      S_M2: begin ma = cy_q; mb = sp_q; end
      S_M3: begin ma = sy_q; mb = sp_q; end
      S_K0, S_K1, S_K2: begin ma = XW'({1'b0, speed_q}); mb = XW'(d_q[k]); end
      S_K3: begin ma = XW'({1'b0, speed_q}); mb = XW'(rt0_q); end
      S_K4: begin ma = XW'({1'b0, speed_q}); mb = XW'(rt2_q); end
      default: ;
    endcase
    creq.start = (st_q == S_YAW) || (st_q == S_PIT);
    creq.angle = (st_q == S_YAW) ? to_q24(yaw_q) : to_q24(pitch_q);
  end

  // yaw wrap: the mouse term spans many turns, so estimate the turn count
  // by reciprocal multiplication in S_WRAP, then subtract and fix up in S_REM
  logic signed [DW-1:0] ysum;
  logic signed [DW+20:0] qprod;
  logic signed [DW-1:0] qest, rem;
  localparam int RecSh = 40;
  localparam logic [31:0] Recip = 32'((64'd1 << RecSh) / (64'd360 << AF)) + 32'd1;
  always_comb begin
    ysum  = DW'(yaw_q) + ddx_q + DW'(HalfA);
    qprod = (DW+21)'(ysum) * $signed({1'b0, Recip});
    qest  = DW'(qprod >>> RecSh);
    rem   = ysum - qest_q * DW'(Full);
    if (rem < 0) rem = rem + DW'(Full);
    if (rem >= DW'(Full)) rem = rem - DW'(Full);
  end

  logic signed [DW-1:0] psum, acc [3];
  logic signed [DW-1:0] spd;
  always_comb begin
    psum = DW'(pitch_q) + ddy_q;
    spd = DW'({1'b0, speed_q});
    for (int j = 0; j < 3; j++) begin
      acc[j] = DW'(pos_q[j]);
      if (it_q.key_mask[0]) acc[j] = acc[j] + fwd_q[j];
      if (it_q.key_mask[1]) acc[j] = acc[j] - fwd_q[j];
      if (it_q.key_mask[2]) acc[j] = acc[j] - side_q[j];
      if (it_q.key_mask[3]) acc[j] = acc[j] + side_q[j];
    end
    if (it_q.key_mask[4]) acc[1] = acc[1] + spd;
    if (it_q.key_mask[5]) acc[1] = acc[1] - spd;
  end

  assign in_if.ready  = (st_q == S_IDLE) && !out_v_q;
  assign out_if.valid = out_v_q;
  assign out_if.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= GainReset;
      speed_q <= SpeedReset;
      pos_q[0] <= '0; pos_q[1] <= '0; pos_q[2] <= '0;
      yaw_q   <= YawReset;
      pitch_q <= '0;
      st_q    <= S_IDLE;
      out_v_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegMouseGain: gain_q <= cfg_wdata_i[GainW-1:0];
          RegMoveSpeed: speed_q <= cfg_wdata_i[SpeedW-1:0];
          default: ;
        endcase
      end
      if (out_v_q && out_if.ready) out_v_q <= 1'b0;
      case (st_q)
        S_IDLE: if (in_if.valid && in_if.ready) st_q <= S_MULX;
        S_MULX: st_q <= S_MULY;
        S_MULY: st_q <= S_WRAP;
        S_WRAP: begin
          if (psum > DW'(PLim)) pitch_q <= PLim;
          else if (psum < -DW'(PLim)) pitch_q <= -PLim;
          else pitch_q <= AW'(psum);
          st_q <= S_REM;
        end
        S_REM: begin
          yaw_q <= AW'(rem - DW'(HalfA));
          st_q  <= S_YAW;
        end
        S_YAW:  st_q <= S_YAWW;
        S_YAWW: if (crsp.done) st_q <= S_PIT;
        S_PIT:  st_q <= S_PITW;
        S_PITW: if (crsp.done) st_q <= S_M0;
        S_M0: st_q <= S_M1;
        S_M1: st_q <= S_M2;
        S_M2: st_q <= S_M3;
        S_M3: st_q <= S_K0;
        S_K0: st_q <= S_K1;
        S_K1: st_q <= S_K2;
        S_K2: st_q <= S_K3;
        S_K3: st_q <= S_K4;
        S_K4: st_q <= S_POS;
        S_POS: begin
          for (int j = 0; j < 3; j++) begin
            if (acc[j] > DW'(32'sh7fffffff)) pos_q[j] <= 32'sh7fffffff;
            else if (acc[j] < -DW'(64'sh80000000)) pos_q[j] <= 32'sh80000000;
            else pos_q[j] <= PosW'(acc[j]);
          end
          st_q <= S_OUT;
        end
        S_OUT: begin
          out_v_q <= 1'b1;
          st_q    <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: if (in_if.valid && in_if.ready) it_q <= in_if.data;
      S_MULX: ddx_q <= rescale_m(mp);
      S_MULY: ddy_q <= rescale_m(mp);
      S_WRAP: qest_q <= qest;
      S_YAWW: if (crsp.done) begin cy_q <= crsp.cos_v; sy_q <= crsp.sin_v; end
      S_PITW: if (crsp.done) begin
        cp_q <= crsp.cos_v; sp_q <= crsp.sin_v;
        d_q[1] <= to14((2*XW)'(crsp.sin_v));
        u_q[1] <= to14((2*XW)'(crsp.cos_v));
        rt0_q  <= to14(-((2*XW)'(sy_q)));
        rt2_q  <= to14((2*XW)'(cy_q));
      end
      S_M0: d_q[0] <= to14(r30(mp));
      S_M1: d_q[2] <= to14(r30(mp));
      S_M2: u_q[0] <= to14(-r30(mp));
      S_M3: u_q[2] <= to14(-r30(mp));
      S_K0: fwd_q[0] <= r14(mp);
      S_K1: fwd_q[1] <= r14(mp);
      S_K2: fwd_q[2] <= r14(mp);
      S_K3: begin side_q[0] <= r14(mp); side_q[1] <= '0; end
      S_K4: side_q[2] <= r14(mp);
      S_OUT: begin
        out_q.pos_x <= pos_q[0]; out_q.pos_y <= pos_q[1]; out_q.pos_z <= pos_q[2];
        out_q.dir_x <= d_q[0]; out_q.dir_y <= d_q[1]; out_q.dir_z <= d_q[2];
        out_q.up_x <= u_q[0]; out_q.up_y <= u_q[1]; out_q.up_z <= u_q[2];
      end
      default: ;
    endcase
  end
endmodule
